// ----- design/met_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time pixel engine.
// Used by the channel interfaces, the controller, the datapath and its units.
package met_pkg;

  localparam int DATA_BITS      = 64;
  localparam int HALF_BITS      = DATA_BITS / 2;
  localparam int PROD_BITS      = 2 * DATA_BITS;
  localparam int INDEX_BITS     = 10;
  localparam int COUNT_BITS     = 20;
  localparam int FRACTION_BITS  = 58;
  localparam int RED_BITS       = 7;
  localparam int GREEN_BITS     = 8;
  localparam int BLUE_BITS      = 8;

  localparam logic [DATA_BITS-1:0]  ESCAPE_BOUND = 64'd4 << FRACTION_BITS;
  localparam logic [COUNT_BITS-1:0] LIMIT_RESET  = 20'd1000;

  localparam int REG_INDEX_BITS = 3;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_ORIGIN_REAL     = 3'd0,
    REG_ORIGIN_IMAG     = 3'd1,
    REG_STEP_REAL       = 3'd2,
    REG_STEP_IMAG       = 3'd3,
    REG_ITERATION_LIMIT = 3'd4
  } reg_index_t;

  // colour lanes: red, green, blue
  localparam int LANES      = 3;
  localparam int SCALE_BITS = 8;
  localparam logic [SCALE_BITS-1:0] COLOUR_SCALE [LANES] = '{8'd127, 8'd169, 8'd250};
  localparam int DIV_BITS      = COUNT_BITS + SCALE_BITS;
  localparam int DIV_STEP_BITS = $clog2(DIV_BITS);

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_FRAC,
    SHIFT_FRAC_LESS_ONE
  } shift_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD_START,
    ST_COORD_WAIT,
    ST_CHECK,
    ST_ITER_WAIT,
    ST_DIV_WAIT,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_coord;
    logic c_load;
    logic update;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic escaped;
    logic at_limit;
    logic div_done;
  } status_t;

endpackage

// ----- design/met_in_if.sv -----
// Pixel request channel: valid, ready and the column and row of one pixel.
// Depends on met_pkg for the index width.
interface met_in_if;
  logic                           valid;
  logic                           ready;
  logic [met_pkg::INDEX_BITS-1:0] column;
  logic [met_pkg::INDEX_BITS-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink (input valid, column, row, output ready);
endinterface

// ----- design/met_out_if.sv -----
// Result channel: valid, ready, the colour channels and the escape count.
// Depends on met_pkg for the field widths.
interface met_out_if;
  logic                           valid;
  logic                           ready;
  logic [met_pkg::RED_BITS-1:0]   red;
  logic [met_pkg::GREEN_BITS-1:0] green;
  logic [met_pkg::BLUE_BITS-1:0]  blue;
  logic [met_pkg::COUNT_BITS-1:0] escape_count;

  modport source (output valid, red, green, blue, escape_count, input ready);
  modport sink (input valid, red, green, blue, escape_count, output ready);
endinterface

// ----- design/mandelbrot_escape_time_pixel.sv -----
// Mandelbrot escape-time pixel engine. Each request carries a pixel column and row;
// the engine forms c = origin + index*step in signed 64-bit fixed point with 58
// fraction bits, iterates z = z*z + c from zero while |z|^2 < 4 and the count is below
// iteration_limit, and returns the count with a colour floor(K*(limit-count)/limit) for
// K = 127, 169, 250 (black for a zero limit). One pixel is in work at a time; its
// time grows with the number of completed iterations and is set by the three 64x64
// multipliers that each build a product from four 33x33 partial products in turn,
// once per iteration before the update, plus the point set-up through two of the same
// multipliers and a 28-step bit-serial colour divider. A finished result waits in an
// output register, so the next request is taken while it is still unread. Write the
// registers only while the engine is idle. Depends on met_pkg, met_in_if, met_out_if.
module mandelbrot_escape_time_pixel (
  input  logic                               clk,
  input  logic                               rst,
  met_in_if.sink                             pixel,
  met_out_if.source                          result,
  input  logic                               write_enable,
  input  logic [met_pkg::REG_INDEX_BITS-1:0] write_index,
  input  logic [met_pkg::DATA_BITS-1:0]      write_data
);

  met_pkg::cmd_t    cmd;
  met_pkg::status_t status;

  met_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  met_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .column       (pixel.column),
    .row          (pixel.row),
    .red          (result.red),
    .green        (result.green),
    .blue         (result.blue),
    .escape_count (result.escape_count)
  );

endmodule

// ----- design/met_mul.sv -----
// Signed 64x64 fixed-point multiplier: four 33x33 partial products, one per cycle,
// accumulated into a 128-bit sum and shifted right by a selectable amount. Uses met_pkg.
module met_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  met_pkg::shift_t               mode,
  input  logic [met_pkg::DATA_BITS-1:0] a,
  input  logic [met_pkg::DATA_BITS-1:0] b,
  output logic                          done,
  output logic [met_pkg::DATA_BITS-1:0] product
);

  localparam int DataBits  = met_pkg::DATA_BITS;
  localparam int HalfBits  = met_pkg::HALF_BITS;
  localparam int ProdBits  = met_pkg::PROD_BITS;
  localparam int OperBits  = HalfBits + 1;
  localparam int PpBits    = 2 * OperBits;
  localparam int Frac      = met_pkg::FRACTION_BITS;
  localparam logic [2:0] LastPhase = 3'd4;

  logic [DataBits-1:0]        a_reg;
  logic [DataBits-1:0]        b_reg;
  met_pkg::shift_t            mode_reg;
  logic                       busy;
  logic [2:0]                 phase;
  logic signed [PpBits-1:0]   pp;
  logic [1:0]                 pp_pos;
  logic [ProdBits-1:0]        acc;

  logic [OperBits-1:0]        op_a;
  logic [OperBits-1:0]        op_b;
  logic [1:0]                 pos;
  logic [ProdBits-1:0]        pp_wide;
  logic [ProdBits-1:0]        pp_ext;
  logic [ProdBits-1:0]        acc_sum;
  logic [DataBits-1:0]        shifted;

  // low halves are unsigned, high halves carry the sign
  always_comb begin
    case (phase[1:0])
      2'd0: begin
        op_a = {1'b0, a_reg[HalfBits-1:0]};
        op_b = {1'b0, b_reg[HalfBits-1:0]};
        pos  = 2'd0;
      end
      2'd1: begin
        op_a = {1'b0, a_reg[HalfBits-1:0]};
        op_b = {b_reg[DataBits-1], b_reg[DataBits-1:HalfBits]};
        pos  = 2'd1;
      end
      2'd2: begin
        op_a = {a_reg[DataBits-1], a_reg[DataBits-1:HalfBits]};
        op_b = {1'b0, b_reg[HalfBits-1:0]};
        pos  = 2'd1;
      end
      default: begin
        op_a = {a_reg[DataBits-1], a_reg[DataBits-1:HalfBits]};
        op_b = {b_reg[DataBits-1], b_reg[DataBits-1:HalfBits]};
        pos  = 2'd2;
      end
    endcase
  end

  always_comb begin
    pp_wide = {{(ProdBits-PpBits){pp[PpBits-1]}}, pp};
    case (pp_pos)
      2'd0:    pp_ext = pp_wide;
      2'd1:    pp_ext = pp_wide << HalfBits;
      default: pp_ext = pp_wide << DataBits;
    endcase
    acc_sum = acc + pp_ext;
    case (mode_reg)
      met_pkg::SHIFT_NONE:          shifted = acc_sum[DataBits-1:0];
      met_pkg::SHIFT_FRAC:          shifted = acc_sum[Frac+DataBits-1:Frac];
      met_pkg::SHIFT_FRAC_LESS_ONE: shifted = acc_sum[Frac+DataBits-2:Frac-1];
      default:                      shifted = acc_sum[DataBits-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 3'd0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == LastPhase) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg    <= a;
      b_reg    <= b;
      mode_reg <= mode;
      acc      <= '0;
    end else if (busy) begin
      if (phase != LastPhase) begin
        pp     <= $signed(op_a) * $signed(op_b);
        pp_pos <= pos;
      end
      // add the partial product taken in the previous cycle
      if (phase != 3'd0) begin
        acc <= acc_sum;
      end
      if (phase == LastPhase) begin
        product <= shifted;
      end
    end
  end

endmodule

// ----- design/met_div.sv -----
// Colour scaler: three restoring dividers, one quotient bit per cycle, giving
// floor(K*rest/limit) for the red, green and blue weights. Uses met_pkg.
module met_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [met_pkg::COUNT_BITS-1:0] limit,
  input  logic [met_pkg::COUNT_BITS-1:0] rest,
  output logic                           done,
  output logic [met_pkg::RED_BITS-1:0]   red,
  output logic [met_pkg::GREEN_BITS-1:0] green,
  output logic [met_pkg::BLUE_BITS-1:0]  blue
);

  localparam int Lanes     = met_pkg::LANES;
  localparam int CountBits = met_pkg::COUNT_BITS;
  localparam int ScaleBits = met_pkg::SCALE_BITS;
  localparam int NumBits   = met_pkg::DIV_BITS;
  localparam int StepBits  = met_pkg::DIV_STEP_BITS;
  localparam logic [StepBits-1:0] LastStep = StepBits'(NumBits - 1);

  logic                  busy;
  logic [StepBits-1:0]   step;
  logic                  zero;
  logic [CountBits-1:0]  divisor;
  logic [NumBits-1:0]    num  [Lanes];
  logic [CountBits-1:0]  rem  [Lanes];
  logic [ScaleBits-1:0]  quot [Lanes];

  logic [CountBits:0]    trial    [Lanes];
  logic                  fits     [Lanes];
  logic [CountBits-1:0]  rem_next [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      trial[l]    = {rem[l], num[l][NumBits-1]};
      fits[l]     = trial[l] >= {1'b0, divisor};
      rem_next[l] = fits[l] ? CountBits'(trial[l] - {1'b0, divisor}) : trial[l][CountBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= limit;
      zero    <= (limit == '0);
      for (int l = 0; l < Lanes; l++) begin
        num[l]  <= {{(NumBits-ScaleBits){1'b0}}, met_pkg::COLOUR_SCALE[l]}
                   * {{ScaleBits{1'b0}}, rest};
        rem[l]  <= '0;
        quot[l] <= '0;
      end
    end else if (busy) begin
      // quotient never exceeds the weight, so the dropped high bits are zero
      for (int l = 0; l < Lanes; l++) begin
        num[l]  <= num[l] << 1;
        rem[l]  <= rem_next[l];
        quot[l] <= {quot[l][ScaleBits-2:0], fits[l]};
      end
    end
  end

  // a zero limit yields black
  assign red   = zero ? '0 : quot[0][met_pkg::RED_BITS-1:0];
  assign green = zero ? '0 : quot[1][met_pkg::GREEN_BITS-1:0];
  assign blue  = zero ? '0 : quot[2][met_pkg::BLUE_BITS-1:0];

endmodule

// ----- design/met_datapath.sv -----
// Datapath: configuration registers, point and orbit registers, three multipliers,
// the colour scaler and the result register. Driven by met_ctrl; uses met_pkg.
module met_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  met_pkg::cmd_t                      cmd,
  output met_pkg::status_t                   status,
  input  logic                               write_enable,
  input  logic [met_pkg::REG_INDEX_BITS-1:0] write_index,
  input  logic [met_pkg::DATA_BITS-1:0]      write_data,
  input  logic [met_pkg::INDEX_BITS-1:0]     column,
  input  logic [met_pkg::INDEX_BITS-1:0]     row,
  output logic [met_pkg::RED_BITS-1:0]       red,
  output logic [met_pkg::GREEN_BITS-1:0]     green,
  output logic [met_pkg::BLUE_BITS-1:0]      blue,
  output logic [met_pkg::COUNT_BITS-1:0]     escape_count
);

  localparam int DataBits  = met_pkg::DATA_BITS;
  localparam int CountBits = met_pkg::COUNT_BITS;
  localparam int IndexBits = met_pkg::INDEX_BITS;

  logic [DataBits-1:0]  origin_real;
  logic [DataBits-1:0]  origin_imag;
  logic [DataBits-1:0]  step_real;
  logic [DataBits-1:0]  step_imag;
  logic [CountBits-1:0] iteration_limit;

  logic [IndexBits-1:0] col_reg;
  logic [IndexBits-1:0] row_reg;
  logic [DataBits-1:0]  cr;
  logic [DataBits-1:0]  ci;
  logic [DataBits-1:0]  x;
  logic [DataBits-1:0]  y;
  logic [CountBits-1:0] count;

  met_pkg::shift_t      sq_mode;
  logic [DataBits-1:0]  re_a;
  logic [DataBits-1:0]  re_b;
  logic [DataBits-1:0]  im_a;
  logic [DataBits-1:0]  im_b;
  logic [DataBits-1:0]  re_prod;
  logic [DataBits-1:0]  im_prod;
  logic [DataBits-1:0]  cross_prod;
  logic                 re_done;
  logic                 im_done;
  logic                 cross_done;
  logic [DataBits-1:0]  mag;

  logic                 div_done;
  logic [CountBits-1:0] rest;
  logic [met_pkg::RED_BITS-1:0]   div_red;
  logic [met_pkg::GREEN_BITS-1:0] div_green;
  logic [met_pkg::BLUE_BITS-1:0]  div_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real     <= '0;
      origin_imag     <= '0;
      step_real       <= '0;
      step_imag       <= '0;
      iteration_limit <= met_pkg::LIMIT_RESET;
    end else if (write_enable) begin
      case (met_pkg::reg_index_t'(write_index))
        met_pkg::REG_ORIGIN_REAL:     origin_real     <= write_data;
        met_pkg::REG_ORIGIN_IMAG:     origin_imag     <= write_data;
        met_pkg::REG_STEP_REAL:       step_real       <= write_data;
        met_pkg::REG_STEP_IMAG:       step_imag       <= write_data;
        met_pkg::REG_ITERATION_LIMIT: iteration_limit <= write_data[CountBits-1:0];
        default: ;
      endcase
    end
  end

  // point set-up reuses the squaring units with the index as one factor
  always_comb begin
    if (cmd.mul_coord) begin
      sq_mode = met_pkg::SHIFT_NONE;
      re_a    = {{(DataBits-IndexBits){1'b0}}, col_reg};
      re_b    = step_real;
      im_a    = {{(DataBits-IndexBits){1'b0}}, row_reg};
      im_b    = step_imag;
    end else begin
      sq_mode = met_pkg::SHIFT_FRAC;
      re_a    = x;
      re_b    = x;
      im_a    = y;
      im_b    = y;
    end
  end

  met_mul u_re_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .mode    (sq_mode),
    .a       (re_a),
    .b       (re_b),
    .done    (re_done),
    .product (re_prod)
  );

  met_mul u_im_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .mode    (sq_mode),
    .a       (im_a),
    .b       (im_b),
    .done    (im_done),
    .product (im_prod)
  );

  met_mul u_cross_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start & ~cmd.mul_coord),
    .mode    (met_pkg::SHIFT_FRAC_LESS_ONE),
    .a       (x),
    .b       (y),
    .done    (cross_done),
    .product (cross_prod)
  );

  assign rest = iteration_limit - count;

  met_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .limit (iteration_limit),
    .rest  (rest),
    .done  (div_done),
    .red   (div_red),
    .green (div_green),
    .blue  (div_blue)
  );

  // a sum that wraps negative stays inside
  assign mag = re_prod + im_prod;

  always_comb begin
    status.mul_done = re_done & im_done & (cross_done | cmd.mul_coord);
    status.escaped  = !($signed(mag) < $signed(met_pkg::ESCAPE_BOUND));
    status.at_limit = count >= iteration_limit;
    status.div_done = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_reg <= column;
      row_reg <= row;
      x       <= '0;
      y       <= '0;
      count   <= '0;
    end
    if (cmd.c_load) begin
      cr <= origin_real + re_prod;
      ci <= origin_imag + im_prod;
    end
    if (cmd.update) begin
      x     <= re_prod - im_prod + cr;
      y     <= cross_prod + ci;
      count <= count + 1'b1;
    end
    if (cmd.out_load) begin
      red          <= div_red;
      green        <= div_green;
      blue         <= div_blue;
      escape_count <= count;
    end
  end

endmodule

// ----- design/met_ctrl.sv -----
// Controller: sequences point set-up, the escape loop, colour scaling and the
// hand-off to the result register. Drives met_datapath; uses met_pkg.
module met_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  met_pkg::status_t status,
  output met_pkg::cmd_t    cmd
);

  met_pkg::state_t state;
  met_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= met_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      met_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = met_pkg::ST_COORD_START;
        end
      end
      met_pkg::ST_COORD_START: begin
        cmd.mul_start = 1'b1;
        cmd.mul_coord = 1'b1;
        state_next    = met_pkg::ST_COORD_WAIT;
      end
      met_pkg::ST_COORD_WAIT: begin
        cmd.mul_coord = 1'b1;
        if (status.mul_done) begin
          cmd.c_load = 1'b1;
          state_next = met_pkg::ST_CHECK;
        end
      end
      met_pkg::ST_CHECK: begin
        if (status.at_limit) begin
          cmd.div_start = 1'b1;
          state_next    = met_pkg::ST_DIV_WAIT;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = met_pkg::ST_ITER_WAIT;
        end
      end
      met_pkg::ST_ITER_WAIT: begin
        if (status.mul_done) begin
          if (status.escaped) begin
            cmd.div_start = 1'b1;
            state_next    = met_pkg::ST_DIV_WAIT;
          end else begin
            cmd.update = 1'b1;
            state_next = met_pkg::ST_CHECK;
          end
        end
      end
      met_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = met_pkg::ST_DELIVER;
        end
      end
      met_pkg::ST_DELIVER: begin
        // hold until the result register is free or being emptied
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = met_pkg::ST_IDLE;
        end
      end
      default: state_next = met_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_mul_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> (state == met_pkg::ST_COORD_WAIT || state == met_pkg::ST_ITER_WAIT))
    else $error("multiplier finished outside a wait state");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == met_pkg::ST_DIV_WAIT)
    else $error("colour scaler finished outside its wait state");

  a_no_count_past_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !status.at_limit)
    else $error("iteration count advanced at the limit");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !$past(cmd.out_load) || out_valid)
    else $error("pending result dropped");

endmodule

// ----- bench/escape_colour_checker.sv -----
// Scoreboard for the Mandelbrot escape-time pixel engine: mirrors the register
// writes, predicts count and colour for each pixel request and checks each result.
// Depends on met_pkg, met_in_if and met_out_if.
module escape_colour_checker
  import met_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  met_in_if                         pixel,
  met_out_if                        result,
  input  logic                      write_enable,
  input  logic [REG_INDEX_BITS-1:0] write_index,
  input  logic [DATA_BITS-1:0]      write_data,
  output int unsigned               failures,
  output int unsigned               awaiting
);

  localparam int unsigned RED_FULL   = 127;
  localparam int unsigned GREEN_FULL = 169;
  localparam int unsigned BLUE_FULL  = 250;

  typedef struct packed {
    logic [RED_BITS-1:0]   red;
    logic [GREEN_BITS-1:0] green;
    logic [BLUE_BITS-1:0]  blue;
    logic [COUNT_BITS-1:0] escape_count;
  } pixel_colour_t;

  logic [DATA_BITS-1:0]  origin_re;
  logic [DATA_BITS-1:0]  origin_im;
  logic [DATA_BITS-1:0]  step_re;
  logic [DATA_BITS-1:0]  step_im;
  logic [COUNT_BITS-1:0] max_iterations;

  pixel_colour_t awaited_colours[$];
  pixel_colour_t want;
  int unsigned   fail_count;

  // floor(a*b / 2^shift) of the exact signed product, low 64 bits kept
  function automatic logic [DATA_BITS-1:0] scaled_product(input logic [DATA_BITS-1:0] a,
                                                          input logic [DATA_BITS-1:0] b,
                                                          input int unsigned shift);
    logic signed [PROD_BITS-1:0] wide_a;
    logic signed [PROD_BITS-1:0] wide_b;
    logic signed [PROD_BITS-1:0] prod;
    wide_a = {{DATA_BITS{a[DATA_BITS-1]}}, a};
    wide_b = {{DATA_BITS{b[DATA_BITS-1]}}, b};
    prod   = wide_a * wide_b;
    prod   = prod >>> shift;
    return prod[DATA_BITS-1:0];
  endfunction

  function automatic pixel_colour_t escape_pixel(input logic [INDEX_BITS-1:0] col,
                                                 input logic [INDEX_BITS-1:0] row);
    logic [DATA_BITS-1:0]  c_re;
    logic [DATA_BITS-1:0]  c_im;
    logic [DATA_BITS-1:0]  zr;
    logic [DATA_BITS-1:0]  zi;
    logic [DATA_BITS-1:0]  zr_sq;
    logic [DATA_BITS-1:0]  zi_sq;
    logic [DATA_BITS-1:0]  cross_term;
    logic [DATA_BITS-1:0]  magnitude;
    logic [DATA_BITS-1:0]  rest;
    logic [DATA_BITS-1:0]  span;
    logic [COUNT_BITS-1:0] n;
    pixel_colour_t         res;
    c_re = origin_re + DATA_BITS'(col) * step_re;
    c_im = origin_im + DATA_BITS'(row) * step_im;
    zr   = '0;
    zi   = '0;
    n    = '0;
    while (n < max_iterations) begin
      zr_sq     = scaled_product(zr, zr, FRACTION_BITS);
      zi_sq     = scaled_product(zi, zi, FRACTION_BITS);
      magnitude = zr_sq + zi_sq;
      // a sum that wrapped negative stays inside
      if (!($signed(magnitude) < $signed(ESCAPE_BOUND))) break;
      cross_term = scaled_product(zr, zi, FRACTION_BITS - 1);
      zr         = zr_sq - zi_sq + c_re;
      zi         = cross_term + c_im;
      n++;
    end
    res.escape_count = n;
    if (max_iterations == '0) begin
      res.red   = '0;
      res.green = '0;
      res.blue  = '0;
    end else begin
      rest      = DATA_BITS'(max_iterations - n);
      span      = DATA_BITS'(max_iterations);
      res.red   = RED_BITS'((DATA_BITS'(RED_FULL) * rest) / span);
      res.green = GREEN_BITS'((DATA_BITS'(GREEN_FULL) * rest) / span);
      res.blue  = BLUE_BITS'((DATA_BITS'(BLUE_FULL) * rest) / span);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      origin_re      = '0;
      origin_im      = '0;
      step_re        = '0;
      step_im        = '0;
      max_iterations = LIMIT_RESET;
      fail_count     = 0;
      awaited_colours.delete();
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_ORIGIN_REAL:     origin_re = write_data;
          REG_ORIGIN_IMAG:     origin_im = write_data;
          REG_STEP_REAL:       step_re = write_data;
          REG_STEP_IMAG:       step_im = write_data;
          REG_ITERATION_LIMIT: max_iterations = write_data[COUNT_BITS-1:0];
          default: ;  // drop writes to spare indexes
        endcase
      end
      if (result.valid && result.ready) begin
        if (awaited_colours.size() == 0) begin
          $error("result with no pixel request awaiting");
          fail_count++;
        end else begin
          want = awaited_colours.pop_front();
          if (result.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, result.red);
            fail_count++;
          end
          if (result.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, result.green);
            fail_count++;
          end
          if (result.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, result.blue);
            fail_count++;
          end
          if (result.escape_count !== want.escape_count) begin
            $error("escape_count: expected %0d, got %0d", want.escape_count,
                   result.escape_count);
            fail_count++;
          end
        end
      end
      if (pixel.valid && pixel.ready) begin
        awaited_colours.push_back(escape_pixel(pixel.column, pixel.row));
      end
    end
    failures <= fail_count;
    awaiting <= awaited_colours.size();
  end

endmodule

// ----- bench/mandelbrot_escape_time_pixel_tb.sv -----
// Top of the pixel engine bench: clock, reset, register set-up, pixel requests and
// result back-pressure, with a watchdog and the verdict.
// Depends on met_pkg, met_in_if, met_out_if, escape_colour_checker and the engine.
module mandelbrot_escape_time_pixel_tb;
  import met_pkg::*;

  localparam int          RANDOM_PHASES  = 10;
  localparam int          PHASE_ITEMS    = 55;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          COLUMNS        = 1024;
  localparam int          ROWS           = 1024;
  localparam int          SPARE_FIRST    = int'(REG_ITERATION_LIMIT) + 1;
  localparam int          INDEX_SPAN     = 1 << REG_INDEX_BITS;

  localparam logic [DATA_BITS-1:0] ONE      = 64'd1 << FRACTION_BITS;
  localparam logic [DATA_BITS-1:0] TWO      = ONE << 1;
  localparam logic [DATA_BITS-1:0] THREE    = ONE * 3;
  localparam logic [DATA_BITS-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [DATA_BITS-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_BITS-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [COUNT_BITS-1:0] LIMIT_MAX = '1;

  logic                      clk;
  logic                      rst;
  logic                      write_enable;
  logic [REG_INDEX_BITS-1:0] write_index;
  logic [DATA_BITS-1:0]      write_data;
  int unsigned               failures;
  int unsigned               awaiting;
  int unsigned               quiet_cycles = 0;
  int unsigned               stall_left = 0;
  bit                        source_gaps;
  bit                        sink_stalls;

  met_in_if  pixel_chan ();
  met_out_if result_chan ();

  mandelbrot_escape_time_pixel i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel_chan),
    .result       (result_chan),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  escape_colour_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel_chan),
    .result       (result_chan),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .failures     (failures),
    .awaiting     (awaiting)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [DATA_BITS-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return INDEX_BITS'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_chan.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      result_chan.ready <= 1'b0;
    end else if (!sink_stalls || $urandom_range(0, 3) != 0) begin
      result_chan.ready <= 1'b1;
    end else begin
      stall_left = gap_length();
      result_chan.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_chan.valid && pixel_chan.ready) ||
        (result_chan.valid && result_chan.ready) || write_enable) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [INDEX_BITS-1:0] col,
                            input logic [INDEX_BITS-1:0] row);
    int unsigned gap;
    gap = (source_gaps && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap != 0) begin
      pixel_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_chan.valid  <= 1'b1;
    pixel_chan.column <= col;
    pixel_chan.row    <= row;
    do @(posedge clk); while (!pixel_chan.ready);
  endtask

  // hold off requests until every result is back, then let the engine settle
  task automatic drain_results();
    pixel_chan.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_INDEX_BITS-1:0] index,
                           input logic [DATA_BITS-1:0] data);
    write_enable <= 1'b1;
    write_index  <= index;
    write_data   <= data;
    @(posedge clk);
  endtask

  task automatic load_view(input logic [DATA_BITS-1:0] o_re, input logic [DATA_BITS-1:0] o_im,
                           input logic [DATA_BITS-1:0] s_re, input logic [DATA_BITS-1:0] s_im,
                           input logic [DATA_BITS-1:0] limit_word, input bit spare);
    drain_results();
    if (spare) begin
      for (int i = SPARE_FIRST; i < INDEX_SPAN; i++) begin
        write_reg(REG_INDEX_BITS'(i), random_word());
      end
    end
    write_reg(REG_ORIGIN_REAL, o_re);
    write_reg(REG_ORIGIN_IMAG, o_im);
    write_reg(REG_STEP_REAL, s_re);
    write_reg(REG_STEP_IMAG, s_im);
    write_reg(REG_ITERATION_LIMIT, limit_word);
    write_enable <= 1'b0;
  endtask

  task automatic random_setting();
    logic [DATA_BITS-1:0]  span;
    logic [DATA_BITS-1:0]  o_re;
    logic [DATA_BITS-1:0]  o_im;
    logic [DATA_BITS-1:0]  s_re;
    logic [DATA_BITS-1:0]  s_im;
    logic [DATA_BITS-1:0]  limit_word;
    logic [COUNT_BITS-1:0] limit;
    int                    style;
    style = int'($urandom_range(0, 3));
    case (style)
      2: begin
        o_re = random_word();
        o_im = random_word();
        s_re = random_word();
        s_im = random_word();
      end
      3: begin
        o_re = random_word() % (ONE * 8) - (ONE * 4);
        o_im = random_word() % (ONE * 8) - (ONE * 4);
        s_re = random_word() >> $urandom_range(6, 40);
        s_im = random_word() >> $urandom_range(6, 40);
        if ($urandom_range(0, 1) != 0) s_re = '0 - s_re;
        if ($urandom_range(0, 1) != 0) s_im = '0 - s_im;
      end
      default: begin
        // window over the set: centre near the boundary, length shrinking by powers of two
        span = THREE >> $urandom_range(0, 24);
        o_re = random_word() % THREE - TWO - (span >> 1);
        o_im = random_word() % (ONE * 5 / 2) - (ONE * 5 / 4) - (span >> 1);
        s_re = span / (COLUMNS - 1);
        s_im = span / (ROWS - 1);
      end
    endcase
    if ($urandom_range(0, 19) == 0) limit = '0;
    else if (style == 2) limit = COUNT_BITS'($urandom_range(1, 16));
    else if ($urandom_range(0, 3) == 0) limit = COUNT_BITS'($urandom_range(49, 160));
    else limit = COUNT_BITS'($urandom_range(1, 48));
    limit_word = ($urandom_range(0, 1) != 0) ? random_word() : '0;
    limit_word[COUNT_BITS-1:0] = limit;
    load_view(o_re, o_im, s_re, s_im, limit_word, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst                <= 1'b1;
    write_enable       <= 1'b0;
    write_index        <= '0;
    write_data         <= '0;
    pixel_chan.valid   <= 1'b0;
    pixel_chan.column  <= '0;
    pixel_chan.row     <= '0;
    sink_stalls        <= 1'b1;
    source_gaps        = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: c at the origin never escapes
    send_pixel('0, '0);
    send_pixel('1, '1);

    // classic full view, corners and a point inside
    load_view('0 - TWO, '0 - (THREE >> 1), THREE / (COLUMNS - 1), THREE / (ROWS - 1),
              64'd64, 1'b0);
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel('0, '1);
    send_pixel('1, '0);
    send_pixel(10'd682, 10'd511);
    send_pixel(10'd341, 10'd511);

    // zero limit gives black, spare indexes ignored
    sink_stalls <= 1'b0;
    load_view('0 - TWO, '0 - (THREE >> 1), THREE / (COLUMNS - 1), THREE / (ROWS - 1),
              64'd0, 1'b1);
    send_pixel(10'd5, 10'd7);
    send_pixel('1, '0);

    // single iteration
    load_view('0 - TWO, '0 - (THREE >> 1), THREE / (COLUMNS - 1), THREE / (ROWS - 1),
              64'd1, 1'b0);
    send_pixel('0, '0);
    send_pixel(10'd682, 10'd511);

    // largest limit, points well outside so they escape after the first iteration
    source_gaps = 1'b0;
    sink_stalls <= 1'b1;
    load_view(THREE, '0, ONE >> 10, ONE >> 10, DATA_BITS'(LIMIT_MAX), 1'b0);
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(10'd511, 10'd300);

    // extreme register values, magnitudes that wrap
    source_gaps = 1'b1;
    load_view(MOST_NEG, MOST_POS, MOST_POS, MOST_NEG, 64'd40, 1'b0);
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(10'd1, 10'd1);
    send_pixel('1, '0);
    send_pixel('0, '1);

    // steps of minus one LSB, limit written with junk above its width
    load_view('0, '0, ALL_ONES, ALL_ONES, {{(DATA_BITS-COUNT_BITS){1'b1}}, 20'd20}, 1'b1);
    send_pixel('1, '1);
    send_pixel(10'd512, 10'd256);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setting();
      source_gaps = $urandom_range(0, 3) != 0;
      sink_stalls <= $urandom_range(0, 3) != 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 49) == 0) drain_results();
        send_pixel(pick_index(), pick_index());
      end
    end

    drain_results();
    if (failures == 0 && awaiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- mandelbrot_escape_time_pixel.f -----
design/met_pkg.sv
design/met_in_if.sv
design/met_out_if.sv
design/met_mul.sv
design/met_div.sv
design/met_datapath.sv
design/met_ctrl.sv
design/mandelbrot_escape_time_pixel.sv
bench/escape_colour_checker.sv
bench/mandelbrot_escape_time_pixel_tb.sv
